>>> hdl/rrcs_pkg.sv
// ----------------------------------------------------------------------------
// rrcs_pkg: shared types and constants of the round-robin CPU scheduler
// Word formats, table entry layout, register indexes and opcodes.
// ----------------------------------------------------------------------------
package rrcs_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = 5;   // width of the task_count register
  localparam int ID_W      = 16;
  localparam int T_W       = 32;
  localparam int Q_W       = 16;
  localparam int SLOT_IN_W = 4;   // width of the slot field of an input word

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_QUANTUM    = 1'b0;
  localparam logic REG_TASK_COUNT = 1'b1;

  localparam logic [Q_W-1:0]   QUANTUM_RST    = Q_W'(4);
  localparam logic [CNT_W-1:0] TASK_COUNT_RST = '0;

  typedef struct packed {
    logic                 opcode;
    logic [SLOT_IN_W-1:0] slot;
    logic [ID_W-1:0]      task_id;
    logic [T_W-1:0]       arrival;
    logic [T_W-1:0]       burst;
  } in_word_t;

  typedef struct packed {
    logic            done_res;
    logic [ID_W-1:0] run_id;
    logic [T_W-1:0]  run_arrival;
    logic [Q_W-1:0]  run_length;
    logic [T_W-1:0]  run_start;
    logic [T_W-1:0]  run_end;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [T_W-1:0]  arrival;
    logic [T_W-1:0]  remaining;
  } task_ent_t;

  // Table access from the sequencer: one write port, one read port
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    task_ent_t         wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } tbl_req_t;

endpackage

>>> hdl/rrcs_table.sv
// ----------------------------------------------------------------------------
// rrcs_table: task table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrcs_table
  import rrcs_pkg::*;
(
  input  logic      clk,
  input  tbl_req_t  req,
  output task_ent_t rdata
);

  task_ent_t mem [MAX_TASKS];
  task_ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data when no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rrcs_ctrl.sv
// ----------------------------------------------------------------------------
// rrcs_ctrl: scheduling sequencer
// Scans the table one slot a cycle, picks the next ready task (else the earliest pending one) and runs it.
// ----------------------------------------------------------------------------
module rrcs_ctrl
  import rrcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic [Q_W-1:0]   quantum,
  input  logic [CNT_W-1:0] task_count,
  output tbl_req_t         tbl_req,
  input  task_ent_t        tbl_rdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_RUN    = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              dv_r, dv_nxt;
  logic [SLOT_W-1:0] didx_r, didx_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic              pend_r, pend_nxt;
  logic [T_W-1:0]    earl_r, earl_nxt;
  logic [SLOT_W-1:0] eidx_r, eidx_nxt;
  logic              hi_f_r, hi_f_nxt;
  logic [SLOT_W-1:0] hi_idx_r, hi_idx_nxt;
  logic              lo_f_r, lo_f_nxt;
  logic [SLOT_W-1:0] lo_idx_r, lo_idx_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [T_W-1:0]    base_r, base_nxt;
  logic [T_W-1:0]    now_r, now_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic              last_vld_r, last_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [CNT_W-1:0]  n_use;
  logic [CNT_W-1:0]  st_try;
  logic              accept;
  logic              out_free;
  logic              rem_nz;
  logic              rdy;
  logic [Q_W-1:0]    q_eff;
  logic [Q_W-1:0]    len;
  logic [T_W-1:0]    len_ext;

  assign n_use    = (task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : task_count;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Per-slot tests on the word just read
  assign rem_nz = (tbl_rdata.remaining != '0);
  assign rdy    = rem_nz && (tbl_rdata.arrival <= now_r);

  assign q_eff   = (quantum == '0) ? Q_W'(1) : quantum;
  assign len     = (tbl_rdata.remaining < T_W'(q_eff)) ? tbl_rdata.remaining[Q_W-1:0] : q_eff;
  assign len_ext = T_W'(len);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    start_nxt     = start_r;
    pend_nxt      = pend_r;
    earl_nxt      = earl_r;
    eidx_nxt      = eidx_r;
    hi_f_nxt      = hi_f_r;
    hi_idx_nxt    = hi_idx_r;
    lo_f_nxt      = lo_f_r;
    lo_idx_nxt    = lo_idx_r;
    sel_nxt       = sel_r;
    base_nxt      = base_r;
    now_nxt       = now_r;
    last_nxt      = last_r;
    last_vld_nxt  = last_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    tbl_req       = '0;
    st_try        = CNT_W'(last_r) + CNT_W'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.opcode == OP_LOAD) begin
            // Drop loads to slots beyond the table
            if (int'(in_word.slot) < MAX_TASKS) begin
              tbl_req.we    = 1'b1;
              tbl_req.waddr = SLOT_W'(in_word.slot);
              tbl_req.wdata = '{id: in_word.task_id, arrival: in_word.arrival,
                                remaining: in_word.burst};
            end
          end else begin
            cnt_nxt  = '0;
            pend_nxt = 1'b0;
            hi_f_nxt = 1'b0;
            lo_f_nxt = 1'b0;
            if (last_vld_r && (CNT_W'(last_r) < n_use) && (st_try < n_use)) begin
              start_nxt = st_try;
            end else begin
              start_nxt = '0;
            end
            state_nxt = (n_use == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next slot read
        if (cnt_r < n_use) begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = cnt_r[SLOT_W-1:0];
          dv_nxt        = 1'b1;
          didx_nxt      = cnt_r[SLOT_W-1:0];
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
        // Fold in the slot read last cycle
        if (dv_r) begin
          if (rem_nz) begin
            if (!pend_r || (tbl_rdata.arrival < earl_r)) begin
              earl_nxt = tbl_rdata.arrival;
              eidx_nxt = didx_r;
            end
            pend_nxt = 1'b1;
          end
          if (rdy) begin
            if (CNT_W'(didx_r) >= start_r) begin
              if (!hi_f_r) begin
                hi_f_nxt   = 1'b1;
                hi_idx_nxt = didx_r;
              end
            end else if (!lo_f_r) begin
              lo_f_nxt   = 1'b1;
              lo_idx_nxt = didx_r;
            end
          end
          if (cnt_r >= n_use) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (!pend_r) begin
          if (out_free) begin
            out_valid_nxt         = 1'b1;
            out_word_nxt          = '0;
            out_word_nxt.done_res = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          if (hi_f_r) begin
            sel_nxt  = hi_idx_r;
            base_nxt = now_r;
          end else if (lo_f_r) begin
            sel_nxt  = lo_idx_r;
            base_nxt = now_r;
          end else begin
            // Nothing ready: idle to the earliest arrival
            sel_nxt  = eidx_r;
            base_nxt = earl_r;
          end
          tbl_req.re    = 1'b1;
          tbl_req.raddr = sel_nxt;
          state_nxt     = ST_RUN;
        end
      end

      ST_RUN: begin
        if (out_free) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = sel_r;
          tbl_req.wdata = '{id: tbl_rdata.id, arrival: tbl_rdata.arrival,
                            remaining: tbl_rdata.remaining - len_ext};
          now_nxt       = base_r + len_ext;
          last_nxt      = sel_r;
          last_vld_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{done_res: 1'b0, run_id: tbl_rdata.id,
                            run_arrival: tbl_rdata.arrival, run_length: len,
                            run_start: base_r, run_end: base_r + len_ext};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dv_r        <= 1'b0;
      now_r       <= '0;
      last_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      now_r       <= now_nxt;
      last_vld_r  <= last_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    didx_r     <= didx_nxt;
    start_r    <= start_nxt;
    pend_r     <= pend_nxt;
    earl_r     <= earl_nxt;
    eidx_r     <= eidx_nxt;
    hi_f_r     <= hi_f_nxt;
    hi_idx_r   <= hi_idx_nxt;
    lo_f_r     <= lo_f_nxt;
    lo_idx_r   <= lo_idx_nxt;
    sel_r      <= sel_nxt;
    base_r     <= base_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Table is written only by a load or at the end of a turn
  a_tbl_write: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.we |-> (state_r == ST_RUN) || (state_r == ST_IDLE && accept))
    else $error("table written outside a load or a turn");

  // A turn always runs at least one tick
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.done_res) |-> (out_word_r.run_length != '0))
    else $error("zero-length turn");

  // A turn ends its length after it starts
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.done_res) |->
      (out_word_r.run_end == out_word_r.run_start + T_W'(out_word_r.run_length)))
    else $error("run_end does not match run_start plus run_length");

  // Time moves only at the end of a turn
  a_now: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(now_r) |-> ($past(state_r) == ST_RUN))
    else $error("tick counter moved outside a turn");

  // Scan never issues past the slots in use
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= n_use))
    else $error("scan ran past the slots in use");

endmodule

>>> hdl/round_robin_cpu_scheduler.sv
// Load word: no result word; in_stall stays low, so the next word can be taken the cycle after.
// Step word: scan of the n slots in use (n at most 16, none when no slot is in use), decision,
//   then a run word or a done word, plus any result stall; in_stall drops as it appears.
// The rate is set by the single table read port, which the scan walks one slot per cycle.
// Synchronous active-low reset: tick counter 0, no last slot, quantum 4, task_count 0;
//   the task table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
// round_robin_cpu_scheduler: round-robin task scheduler with a time quantum
// Holds a task table, picks the next ready task in circular order and reports
// one result word, run or done, per step; configuration over an APB-style port.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler
  import rrcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [Q_W-1:0]   quantum_r, quantum_nxt;
  logic [CNT_W-1:0] task_count_r, task_count_nxt;
  logic             cfg_wr;
  logic             reg_sel;
  tbl_req_t         tbl_req;
  task_ent_t        tbl_rdata;

  // Register index is the word address; pready never stalls
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    quantum_nxt    = quantum_r;
    task_count_nxt = task_count_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_QUANTUM:    quantum_nxt    = cfg_pwdata[Q_W-1:0];
        REG_TASK_COUNT: task_count_nxt = cfg_pwdata[CNT_W-1:0];
        default:        quantum_nxt    = quantum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r    <= QUANTUM_RST;
      task_count_r <= TASK_COUNT_RST;
    end else begin
      quantum_r    <= quantum_nxt;
      task_count_r <= task_count_nxt;
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    case (reg_sel)
      REG_QUANTUM:    cfg_prdata = 32'(quantum_r);
      REG_TASK_COUNT: cfg_prdata = 32'(task_count_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer: scans the table, decides, runs one turn, holds the result word
  rrcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .quantum    (quantum_r),
    .task_count (task_count_r),
    .tbl_req    (tbl_req),
    .tbl_rdata  (tbl_rdata)
  );

  // Task table: id, arrival and remaining burst per slot
  rrcs_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

endmodule
